// File: sv/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants shared by the frontier score selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  localparam int unsigned MAX_FRONTIERS = 1024;
  localparam int unsigned FRAC_BITS     = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OIDX_W  = 10;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned IDX_W   = $clog2(MAX_FRONTIERS);

  // distance datapath
  localparam int unsigned MAG_W  = COORD_W;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned RT_W   = MAG_W + 2;
  localparam int unsigned RAD_W  = 2 * RT_W;
  localparam int unsigned SREM_W = RT_W + 2;
  localparam int unsigned DEN_W  = RT_W;
  localparam int unsigned NUM_W  = SIZE_W + 2 * FRAC_BITS;

  localparam int unsigned SQ_CYC   = 4;
  localparam int unsigned ROOT_CYC = RT_W / 2;
  localparam int unsigned DIV_CYC  = NUM_W / 2;
  localparam int unsigned STEP_MAX = (ROOT_CYC > DIV_CYC) ? ROOT_CYC : DIV_CYC;
  localparam int unsigned CNT_W    = $clog2(STEP_MAX);

  localparam logic [DEN_W-1:0] ONE_FX    = DEN_W'(1) << FRAC_BITS;
  localparam logic [NUM_W-1:0] SAT_LIMIT = NUM_W'(64'h0000_0000_FFFF_FFFF);

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROBOT_X = 2'd0,
    CFG_ROBOT_Y = 2'd1,
    CFG_ROBOT_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [SIZE_W-1:0]  frontier_size;
    logic                      last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] best_x;
    logic signed [COORD_W-1:0] best_y;
    logic signed [COORD_W-1:0] best_z;
    logic        [OIDX_W-1:0]  best_index;
    logic        [SCORE_W-1:0] best_value;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] addr;
    logic [COORD_W-1:0]   wdata;
  } cfg_item_t;

  // one classified candidate waiting for the scoring unit
  typedef struct packed {
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [MAG_W-1:0]   mag_z;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_z;
    logic [SIZE_W-1:0]  frontier_size;
    logic               last_item;
  } work_t;

endpackage

`default_nettype wire

// File: sv/fss_chan_if.sv
// ----------------------------------------------------------------------------
// fss_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: sv/fss_front.sv
// ----------------------------------------------------------------------------
// fss_front
// Robot position registers, request intake and per-axis distance magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  fss_chan_if.sink           cfg_i,
  fss_chan_if.sink           in_i,
  input  wire logic          q_full_i,
  output logic               push_valid_o,
  output fss_pkg::work_t     push_data_o
);

  import fss_pkg::*;

  logic [COORD_W-1:0] robot_x_q, robot_y_q, robot_z_q;
  logic [MAG_W-1:0]   mag_x, mag_y, mag_z;
  in_item_t           item;

  function automatic logic [MAG_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q <= '0;
      robot_y_q <= '0;
      robot_z_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.addr))
        CFG_ROBOT_X: robot_x_q <= cfg_i.data.wdata;
        CFG_ROBOT_Y: robot_y_q <= cfg_i.data.wdata;
        CFG_ROBOT_Z: robot_z_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  assign item  = in_i.data;
  assign mag_x = abs_diff(item.center_x, robot_x_q);
  assign mag_y = abs_diff(item.center_y, robot_y_q);
  assign mag_z = abs_diff(item.center_z, robot_z_q);

  assign in_i.ready   = !q_full_i;
  assign push_valid_o = in_i.valid && !q_full_i;

  always_comb begin
    push_data_o.mag_x         = mag_x;
    push_data_o.mag_y         = mag_y;
    push_data_o.mag_z         = mag_z;
    push_data_o.center_x      = item.center_x;
    push_data_o.center_y      = item.center_y;
    push_data_o.center_z      = item.center_z;
    push_data_o.frontier_size = item.frontier_size;
    push_data_o.last_item     = item.last_item;
  end

endmodule

`default_nettype wire

// File: sv/fss_queue.sv
// ----------------------------------------------------------------------------
// fss_queue
// Two-entry queue between intake and the scoring unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fss_pkg::work_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output fss_pkg::work_t       data_o
);

  import fss_pkg::*;

  work_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// File: sv/fss_back.sv
// ----------------------------------------------------------------------------
// fss_back
// Scoring sequencer: sum of squares, two-digit-per-cycle square root,
// two-bit-per-cycle divide, running best and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire fss_pkg::work_t  q_data_i,
  output logic                 q_pop_o,
  fss_chan_if.source           out_o
);

  import fss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_UPD
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    step_q, step_d;
  work_t               w_q;
  logic [MAG_W-1:0]    mag;
  logic [SQ_W-1:0]     sq_w, sq_q;
  logic [RAD_W-1:0]    acc_q, rad_d;
  logic [SREM_W-1:0]   srem_q, srem_d;
  logic [RT_W-1:0]     root_q, root_d;
  logic [DEN_W-1:0]    den_q, drem_q, drem_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [SREM_W-1:0]   trial;
  logic [DEN_W:0]      dtmp;
  logic [SCORE_W-1:0]  score;
  logic [SCORE_W-1:0]  held_score_q;
  logic [COORD_W-1:0]  held_x_q, held_y_q, held_z_q;
  logic [IDX_W-1:0]    held_idx_q, cnt_q;
  logic                have_q, out_valid_q;
  out_item_t           res_q;
  logic                take, emit_ok, upd_go, step_end;

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    case (step_q)
      CNT_W'(0): mag = w_q.mag_x;
      CNT_W'(1): mag = w_q.mag_y;
      default:   mag = w_q.mag_z;
    endcase
  end

  assign sq_w = SQ_W'(mag) * SQ_W'(mag);

  // two root digits per cycle
  always_comb begin
    srem_d = srem_q;
    root_d = root_q;
    rad_d  = acc_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      srem_d = {srem_d[SREM_W-3:0], rad_d[RAD_W-1:RAD_W-2]};
      rad_d  = {rad_d[RAD_W-3:0], 2'b00};
      trial  = {root_d, 2'b01};
      if (srem_d >= trial) begin
        srem_d = srem_d - trial;
        root_d = {root_d[RT_W-2:0], 1'b1};
      end else begin
        root_d = {root_d[RT_W-2:0], 1'b0};
      end
    end
  end

  // two quotient bits per cycle
  always_comb begin
    drem_d = drem_q;
    num_d  = num_q;
    dtmp   = '0;
    for (int k = 0; k < 2; k++) begin
      dtmp  = {drem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (dtmp >= {1'b0, den_q}) begin
        dtmp     = dtmp - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      drem_d = dtmp[DEN_W-1:0];
    end
  end

  assign score   = (num_q > SAT_LIMIT) ? '1 : num_q[SCORE_W-1:0];
  assign take    = !have_q || (score > held_score_q);
  assign emit_ok = !out_valid_q || out_o.ready;
  assign upd_go  = (state_q == ST_UPD) && (!w_q.last_item || emit_ok);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q + CNT_W'(1);
    step_end = 1'b0;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (q_pop_o) state_d = ST_SQ;
      end
      ST_SQ: begin
        step_end = step_q == CNT_W'(SQ_CYC - 1);
        if (step_end) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        step_end = step_q == CNT_W'(ROOT_CYC - 1);
        if (step_end) state_d = ST_DIV;
      end
      ST_DIV: begin
        step_end = step_q == CNT_W'(DIV_CYC - 1);
        if (step_end) state_d = ST_UPD;
      end
      ST_UPD: begin
        step_d = '0;
        if (upd_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (step_end) step_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (upd_go) begin
        have_q <= !w_q.last_item;
        if (w_q.last_item || cnt_q == IDX_W'(MAX_FRONTIERS - 1)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
      end
      if (upd_go && w_q.last_item) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          w_q    <= q_data_i;
          acc_q  <= '0;
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQ: begin
        sq_q <= sq_w;
        if (step_q != '0) acc_q <= acc_q + RAD_W'(sq_q);
      end
      ST_ROOT: begin
        acc_q  <= rad_d;
        srem_q <= srem_d;
        root_q <= root_d;
        if (step_end) begin
          den_q  <= DEN_W'(root_d) + ONE_FX;
          num_q  <= NUM_W'(w_q.frontier_size) << (2 * FRAC_BITS);
          drem_q <= '0;
        end
      end
      ST_DIV: begin
        num_q  <= num_d;
        drem_q <= drem_d;
      end
      ST_UPD: begin
        if (upd_go && take) begin
          held_score_q <= score;
          held_x_q     <= w_q.center_x;
          held_y_q     <= w_q.center_y;
          held_z_q     <= w_q.center_z;
          held_idx_q   <= cnt_q;
        end
        if (upd_go && w_q.last_item) begin
          res_q.best_x     <= take ? w_q.center_x : held_x_q;
          res_q.best_y     <= take ? w_q.center_y : held_y_q;
          res_q.best_z     <= take ? w_q.center_z : held_z_q;
          res_q.best_index <= OIDX_W'(take ? cnt_q : held_idx_q);
          res_q.best_value <= take ? score : held_score_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule

`default_nettype wire

// File: sv/frontier_score_select.sv
// ----------------------------------------------------------------------------
// frontier_score_select
// Picks the best exploration frontier of a batch by size over one plus
// distance to the robot.
// ----------------------------------------------------------------------------
// Write robot_x/y/z (Q16.16) through cfg_i, then stream candidates on in_i;
// the candidate flagged last_item closes the batch and one result (winner's
// centre, batch index, Q16.16 score) appears on out_o, after which the
// running best is cleared. Ties keep the earlier candidate. Each candidate
// passes in turn through the single scoring unit: a load, the sum of
// squares through one 32x32 multiplier, the square root at two digits a
// cycle and the divide at two quotient bits a cycle, then an update of the
// best. A two-entry queue lets intake run ahead of scoring and the result
// register lets scoring continue while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module frontier_score_select (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fss_chan_if.sink   cfg_i,
  fss_chan_if.sink   in_i,
  fss_chan_if.source out_o
);

  import fss_pkg::*;

  logic  push_valid, q_full, q_valid, q_pop;
  work_t push_data, q_data;

  fss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  fss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  fss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// File: sv/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks on results against closed batches.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                in_last_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire fss_pkg::out_item_t  out_data_i
);

  import fss_pkg::*;

  localparam logic [2:0] MAX_PEND = 3'd4;

  logic [2:0] pend_q;
  logic       close_w, done_w;

  assign close_w = in_valid_i && in_ready_i && in_last_i;
  assign done_w  = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({close_w, done_w})
        2'b10:   pend_q <= pend_q + 3'd1;
        2'b01:   pend_q <= pend_q - 3'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without a closed batch");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PEND)
    else $error("intake not throttled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind frontier_score_select fss_checker u_fss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.data.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
